[sv/variable_partition_allocator_unit_defines.svh]
// Assertion macros for the partition allocator.
// Define NO_ASSERTIONS to compile them out.
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VPA_ASSERT_IMP(lbl, ante, cons, msg)
`define VPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/vpa_pkg.sv]
package vpa_pkg;

  // Table sizes and the widths that follow from them.
  localparam int FREE_SLOTS = 64;
  localparam int USED_SLOTS = 64;
  localparam int FREE_AW    = $clog2(FREE_SLOTS);
  localparam int USED_AW    = $clog2(USED_SLOTS);
  localparam int FREE_CW    = $clog2(FREE_SLOTS + 1);
  localparam int USED_CW    = $clog2(USED_SLOTS + 1);
  localparam int SCAN_W     = (FREE_CW > USED_CW) ? FREE_CW : USED_CW;
  localparam int ENTRY_W    = 32;
  localparam int APB_AW     = 3;

  // Fit policies.
  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_NEXT  = 2'd1;
  localparam logic [1:0] POLICY_BEST  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT     = 2'd1;
  localparam logic [1:0] STATUS_FULL       = 2'd2;
  localparam logic [1:0] STATUS_NOT_ALLOC  = 2'd3;

  // Item kinds.
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Register indexes.
  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_POOL_SIZE  = 1'b1;

  // Reset values of the registers.
  localparam logic [1:0]  POLICY_RESET = POLICY_BEST;
  localparam logic [15:0] POOL_RESET   = 16'd10000;

  localparam logic [6:0] PROBES_MAX = 7'h7F;

  typedef struct packed {
    logic        kind;
    logic [15:0] req_size;
    logic [15:0] release_addr;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_addr;
    logic [6:0]  probes;
  } result_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_CHECK,
    OP_ASCAN,
    OP_ACARVE,
    OP_FDOWN,
    OP_RUSCAN,
    OP_RCHK,
    OP_RFSCAN,
    OP_RMERGE,
    OP_FUP,
    OP_RINS,
    OP_UDOWN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic first;
    logic load_item;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic is_release;
    logic zero_req;
    logic used_full;
    logic found;
    logic need_remove;
    logic hit;
    logic merge_l;
    logic merge_r;
    logic free_full;
  } stat_t;

endpackage

[sv/vpa_ram.sv]
module vpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/vpa_datapath.sv]
module vpa_datapath (
  input  logic             clk,
  input  logic             rst,
  input  vpa_pkg::cmd_t    cmd,
  output vpa_pkg::stat_t   stat,
  input  vpa_pkg::item_t   in_data,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [31:0]      cfg_wdata,
  output logic [1:0]       fit_policy,
  output logic [15:0]      pool_size,
  output vpa_pkg::result_t out_data
);

  logic                         f_we, u_we;
  logic [vpa_pkg::FREE_AW-1:0]  f_waddr, f_raddr;
  logic [vpa_pkg::USED_AW-1:0]  u_waddr, u_raddr;
  logic [vpa_pkg::ENTRY_W-1:0]  f_wdata, f_rdata, u_wdata, u_rdata;

  vpa_pkg::item_t               item;
  vpa_pkg::result_t             res;
  logic [vpa_pkg::FREE_CW-1:0]  fc, new_fc, pos, pos_m1;
  logic [vpa_pkg::USED_CW-1:0]  uc;
  logic [vpa_pkg::FREE_AW-1:0]  rover, best_idx, sidx;
  logic [vpa_pkg::USED_AW-1:0]  uj;
  logic [vpa_pkg::SCAN_W-1:0]   k, pidx, k_cur, next_k, next_pidx;
  logic [vpa_pkg::SCAN_W-1:0]   scan_limit, scan_addr, sh_r, sh_rm1, pidx_m1, pidx_p1;
  logic [vpa_pkg::FREE_CW:0]    rstart, nsum, nidx;
  logic                         pv, stop, pv_cur, stop_cur, issue, eval_stop;
  logic                         found, hit, greedy, fits, ml, mr;
  logic [15:0]                  best_start, best_len, ulen;
  logic [15:0]                  prev_start, prev_len, cur_start, cur_len;
  logic [15:0]                  f_start, f_len, u_start, u_len;
  logic [6:0]                   probes;
  logic [16:0]                  left_end, right_end;

  vpa_ram #(.WIDTH(vpa_pkg::ENTRY_W), .DEPTH(vpa_pkg::FREE_SLOTS)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  vpa_ram #(.WIDTH(vpa_pkg::ENTRY_W), .DEPTH(vpa_pkg::USED_SLOTS)) u_used_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  // Entry fields as they come out of the tables.
  assign f_start = f_rdata[31:16];
  assign f_len   = f_rdata[15:0];
  assign u_start = u_rdata[31:16];
  assign u_len   = u_rdata[15:0];

  // The scan pipeline restarts on the first cycle of each operation.
  assign k_cur    = cmd.first ? '0 : k;
  assign pv_cur   = cmd.first ? 1'b0 : pv;
  assign stop_cur = cmd.first ? 1'b0 : stop;

  assign greedy = (fit_policy == vpa_pkg::POLICY_FIRST) || (fit_policy == vpa_pkg::POLICY_NEXT);
  assign fits   = f_len >= item.req_size;

  // Next fit starts at the roving index and wraps once round the table.
  assign rstart = ((vpa_pkg::FREE_CW)'(rover) < fc) ? (vpa_pkg::FREE_CW + 1)'(rover) : '0;
  assign nsum   = rstart + (vpa_pkg::FREE_CW + 1)'(k_cur);
  assign nidx   = (nsum >= {1'b0, fc}) ? nsum - {1'b0, fc} : nsum;

  assign scan_limit = (cmd.op == vpa_pkg::OP_RUSCAN) ? (vpa_pkg::SCAN_W)'(uc)
                                                    : (vpa_pkg::SCAN_W)'(fc);
  assign scan_addr  = (cmd.op == vpa_pkg::OP_ASCAN && fit_policy == vpa_pkg::POLICY_NEXT)
                      ? (vpa_pkg::SCAN_W)'(nidx) : k_cur;

  assign pidx_m1 = pidx - 1'b1;
  assign pidx_p1 = pidx + 1'b1;
  assign pos_m1  = pos - 1'b1;
  assign new_fc  = stat.need_remove ? fc - 1'b1 : fc;

  // Neighbour merge tests for a release.
  assign left_end  = {1'b0, prev_start} + {1'b0, prev_len};
  assign right_end = {1'b0, item.release_addr} + {1'b0, ulen};
  assign ml = (pos != '0) && (left_end == {1'b0, item.release_addr});
  assign mr = (pos < fc) && (right_end == {1'b0, cur_start});

  // Shift pointer for the table moves.
  always_comb begin
    sh_r = k;
    if (cmd.first) begin
      unique case (cmd.op)
        vpa_pkg::OP_FDOWN: sh_r = (vpa_pkg::SCAN_W)'(sidx) + 1'b1;
        vpa_pkg::OP_UDOWN: sh_r = (vpa_pkg::SCAN_W)'(uj) + 1'b1;
        vpa_pkg::OP_FUP:   sh_r = (vpa_pkg::SCAN_W)'(fc);
        default:           sh_r = k;
      endcase
    end
  end
  assign sh_rm1 = sh_r - 1'b1;

  // Table ports and the issue of reads for each operation.
  always_comb begin
    f_we      = 1'b0;
    f_waddr   = '0;
    f_wdata   = '0;
    f_raddr   = '0;
    u_we      = 1'b0;
    u_waddr   = '0;
    u_wdata   = '0;
    u_raddr   = '0;
    issue     = 1'b0;
    eval_stop = 1'b0;
    next_k    = k_cur + 1'b1;
    next_pidx = scan_addr;
    case (cmd.op)
      vpa_pkg::OP_INIT: begin
        f_we    = 1'b1;
        f_wdata = {16'd0, pool_size};
      end
      vpa_pkg::OP_ASCAN: begin
        eval_stop = pv_cur && !stop_cur && greedy && fits;
        issue     = (k_cur < scan_limit) && !stop_cur && !eval_stop;
        f_raddr   = scan_addr[vpa_pkg::FREE_AW-1:0];
      end
      vpa_pkg::OP_RFSCAN: begin
        eval_stop = pv_cur && !stop_cur && (f_start > item.release_addr);
        issue     = (k_cur < scan_limit) && !stop_cur && !eval_stop;
        f_raddr   = scan_addr[vpa_pkg::FREE_AW-1:0];
      end
      vpa_pkg::OP_RUSCAN: begin
        eval_stop = pv_cur && !stop_cur && (u_start == item.release_addr);
        issue     = (k_cur < scan_limit) && !stop_cur && !eval_stop;
        u_raddr   = k_cur[vpa_pkg::USED_AW-1:0];
      end
      vpa_pkg::OP_ACARVE: begin
        if (found) begin
          u_we    = 1'b1;
          u_waddr = uc[vpa_pkg::USED_AW-1:0];
          u_wdata = {best_start, item.req_size};
          if (best_len > item.req_size) begin
            f_we    = 1'b1;
            f_waddr = best_idx;
            f_wdata = {best_start + item.req_size, best_len - item.req_size};
          end
        end
      end
      vpa_pkg::OP_FDOWN: begin
        issue     = sh_r <= (vpa_pkg::SCAN_W)'(fc);
        f_raddr   = sh_r[vpa_pkg::FREE_AW-1:0];
        next_k    = sh_r + 1'b1;
        next_pidx = sh_r;
        if (pv_cur) begin
          f_we    = 1'b1;
          f_waddr = pidx_m1[vpa_pkg::FREE_AW-1:0];
          f_wdata = f_rdata;
        end
      end
      vpa_pkg::OP_UDOWN: begin
        issue     = sh_r <= (vpa_pkg::SCAN_W)'(uc);
        u_raddr   = sh_r[vpa_pkg::USED_AW-1:0];
        next_k    = sh_r + 1'b1;
        next_pidx = sh_r;
        if (pv_cur) begin
          u_we    = 1'b1;
          u_waddr = pidx_m1[vpa_pkg::USED_AW-1:0];
          u_wdata = u_rdata;
        end
      end
      vpa_pkg::OP_FUP: begin
        issue     = sh_r > (vpa_pkg::SCAN_W)'(pos);
        f_raddr   = sh_rm1[vpa_pkg::FREE_AW-1:0];
        next_k    = sh_rm1;
        next_pidx = sh_rm1;
        if (pv_cur) begin
          f_we    = 1'b1;
          f_waddr = pidx_p1[vpa_pkg::FREE_AW-1:0];
          f_wdata = f_rdata;
        end
      end
      vpa_pkg::OP_RMERGE: begin
        if (ml) begin
          f_we    = 1'b1;
          f_waddr = pos_m1[vpa_pkg::FREE_AW-1:0];
          f_wdata = mr ? {prev_start, prev_len + ulen + cur_len} : {prev_start, prev_len + ulen};
        end else if (mr) begin
          f_we    = 1'b1;
          f_waddr = pos[vpa_pkg::FREE_AW-1:0];
          f_wdata = {item.release_addr, cur_len + ulen};
        end
      end
      vpa_pkg::OP_RINS: begin
        f_we    = 1'b1;
        f_waddr = pos[vpa_pkg::FREE_AW-1:0];
        f_wdata = {item.release_addr, ulen};
      end
      default: begin
      end
    endcase
    // A pool size write rebuilds the pool as one segment (none for size zero).
    if (cfg_we && cfg_idx == vpa_pkg::REG_POOL_SIZE) begin
      f_we    = 1'b1;
      f_waddr = '0;
      f_wdata = {16'd0, cfg_wdata[15:0]};
    end
  end

  // Status towards the controller.
  always_comb begin
    stat.done        = !issue;
    stat.is_release  = item.kind == vpa_pkg::KIND_RELEASE;
    stat.zero_req    = item.req_size == 16'd0;
    stat.used_full   = uc >= (vpa_pkg::USED_CW)'(vpa_pkg::USED_SLOTS);
    stat.found       = found;
    stat.need_remove = best_len == item.req_size;
    stat.hit         = hit;
    stat.merge_l     = ml;
    stat.merge_r     = mr;
    stat.free_full   = fc >= (vpa_pkg::FREE_CW)'(vpa_pkg::FREE_SLOTS);
  end

  // Control state of the tables and the registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= vpa_pkg::POLICY_RESET;
      pool_size  <= vpa_pkg::POOL_RESET;
      fc         <= '0;
      uc         <= '0;
      rover      <= '0;
      pv         <= 1'b0;
      stop       <= 1'b0;
      found      <= 1'b0;
      hit        <= 1'b0;
    end else begin
      pv   <= issue;
      stop <= stop_cur | eval_stop;
      case (cmd.op)
        vpa_pkg::OP_INIT: begin
          fc    <= (vpa_pkg::FREE_CW)'(pool_size != 16'd0);
          uc    <= '0;
          rover <= '0;
        end
        vpa_pkg::OP_ASCAN: begin
          if (cmd.first) begin
            found <= 1'b0;
          end
          if (pv_cur && !stop_cur && fits && (greedy || !found || f_len < best_len)) begin
            found <= 1'b1;
          end
        end
        vpa_pkg::OP_ACARVE: begin
          if (found) begin
            uc <= uc + 1'b1;
            if (stat.need_remove) begin
              fc <= fc - 1'b1;
            end
            if (fit_policy == vpa_pkg::POLICY_NEXT) begin
              rover <= ((vpa_pkg::FREE_CW)'(best_idx) < new_fc) ? best_idx : '0;
            end
          end
        end
        vpa_pkg::OP_RUSCAN: begin
          if (cmd.first) begin
            hit <= 1'b0;
          end
          if (eval_stop) begin
            hit <= 1'b1;
          end
        end
        vpa_pkg::OP_RMERGE: begin
          if (ml && mr) begin
            fc <= fc - 1'b1;
            uc <= uc - 1'b1;
          end else if (ml || mr || !stat.free_full) begin
            uc <= uc - 1'b1;
          end
        end
        vpa_pkg::OP_RINS: begin
          fc <= fc + 1'b1;
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        case (cfg_idx)
          vpa_pkg::REG_FIT_POLICY: fit_policy <= cfg_wdata[1:0];
          vpa_pkg::REG_POOL_SIZE: begin
            pool_size <= cfg_wdata[15:0];
            fc        <= (vpa_pkg::FREE_CW)'(cfg_wdata[15:0] != 16'd0);
            uc        <= '0;
            rover     <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Working values of the current word.
  always_ff @(posedge clk) begin
    if (issue) begin
      k    <= next_k;
      pidx <= next_pidx;
    end
    if (cmd.load_item) begin
      item         <= in_data;
      res.status   <= vpa_pkg::STATUS_OK;
      res.block_addr <= (in_data.kind == vpa_pkg::KIND_RELEASE) ? in_data.release_addr : 16'd0;
      res.probes   <= '0;
    end
    case (cmd.op)
      vpa_pkg::OP_CHECK: begin
        if (item.kind == vpa_pkg::KIND_ALLOC) begin
          if (stat.zero_req) begin
            res.status <= vpa_pkg::STATUS_NO_FIT;
          end else if (stat.used_full) begin
            res.status <= vpa_pkg::STATUS_FULL;
          end
        end
      end
      vpa_pkg::OP_ASCAN: begin
        if (cmd.first) begin
          probes <= '0;
        end
        if (pv_cur && !stop_cur) begin
          if (!fits) begin
            if (probes != vpa_pkg::PROBES_MAX) begin
              probes <= probes + 1'b1;
            end
          end else if (greedy || !found || f_len < best_len) begin
            best_idx   <= pidx[vpa_pkg::FREE_AW-1:0];
            best_start <= f_start;
            best_len   <= f_len;
          end
        end
      end
      vpa_pkg::OP_ACARVE: begin
        res.probes <= probes;
        sidx       <= best_idx;
        if (found) begin
          res.block_addr <= best_start;
        end else begin
          res.status <= vpa_pkg::STATUS_NO_FIT;
        end
      end
      vpa_pkg::OP_RUSCAN: begin
        if (eval_stop) begin
          uj   <= pidx[vpa_pkg::USED_AW-1:0];
          ulen <= u_len;
        end
      end
      vpa_pkg::OP_RCHK: begin
        if (!hit) begin
          res.status <= vpa_pkg::STATUS_NOT_ALLOC;
        end
      end
      vpa_pkg::OP_RFSCAN: begin
        if (cmd.first) begin
          pos <= fc;
        end
        if (pv_cur && !stop_cur) begin
          if (f_start > item.release_addr) begin
            pos       <= (vpa_pkg::FREE_CW)'(pidx);
            cur_start <= f_start;
            cur_len   <= f_len;
          end else begin
            prev_start <= f_start;
            prev_len   <= f_len;
          end
        end
      end
      vpa_pkg::OP_RMERGE: begin
        sidx <= pos[vpa_pkg::FREE_AW-1:0];
        if (!ml && !mr && stat.free_full) begin
          res.status <= vpa_pkg::STATUS_FULL;
        end
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

endmodule

[sv/vpa_ctrl.sv]
module vpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  vpa_pkg::stat_t stat,
  output vpa_pkg::cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_INIT   = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_CHECK  = 14'b00000000000100,
    S_ASCAN  = 14'b00000000001000,
    S_ACARVE = 14'b00000000010000,
    S_FDOWN  = 14'b00000000100000,
    S_RUSCAN = 14'b00000001000000,
    S_RCHK   = 14'b00000010000000,
    S_RFSCAN = 14'b00000100000000,
    S_RMERGE = 14'b00001000000000,
    S_FUP    = 14'b00010000000000,
    S_RINS   = 14'b00100000000000,
    S_UDOWN  = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   first;

  // Sequencing of the datapath operations.
  always_comb begin
    state_next    = state;
    cmd.op        = vpa_pkg::OP_NONE;
    cmd.first     = first;
    cmd.load_item = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.op     = vpa_pkg::OP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op = vpa_pkg::OP_CHECK;
        if (stat.is_release) begin
          state_next = S_RUSCAN;
        end else if (stat.zero_req || stat.used_full) begin
          state_next = S_DONE;
        end else begin
          state_next = S_ASCAN;
        end
      end
      S_ASCAN: begin
        cmd.op = vpa_pkg::OP_ASCAN;
        if (stat.done) begin
          state_next = S_ACARVE;
        end
      end
      S_ACARVE: begin
        cmd.op     = vpa_pkg::OP_ACARVE;
        state_next = (stat.found && stat.need_remove) ? S_FDOWN : S_DONE;
      end
      S_FDOWN: begin
        cmd.op = vpa_pkg::OP_FDOWN;
        if (stat.done) begin
          state_next = stat.is_release ? S_UDOWN : S_DONE;
        end
      end
      S_RUSCAN: begin
        cmd.op = vpa_pkg::OP_RUSCAN;
        if (stat.done) begin
          state_next = S_RCHK;
        end
      end
      S_RCHK: begin
        cmd.op     = vpa_pkg::OP_RCHK;
        state_next = stat.hit ? S_RFSCAN : S_DONE;
      end
      S_RFSCAN: begin
        cmd.op = vpa_pkg::OP_RFSCAN;
        if (stat.done) begin
          state_next = S_RMERGE;
        end
      end
      S_RMERGE: begin
        cmd.op = vpa_pkg::OP_RMERGE;
        if (stat.merge_l && stat.merge_r) begin
          state_next = S_FDOWN;
        end else if (stat.merge_l || stat.merge_r) begin
          state_next = S_UDOWN;
        end else if (stat.free_full) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FUP;
        end
      end
      S_FUP: begin
        cmd.op = vpa_pkg::OP_FUP;
        if (stat.done) begin
          state_next = S_RINS;
        end
      end
      S_RINS: begin
        cmd.op     = vpa_pkg::OP_RINS;
        state_next = S_UDOWN;
      end
      S_UDOWN: begin
        cmd.op = vpa_pkg::OP_UDOWN;
        if (stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // State register; the first cycle of each state restarts its operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      first     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      first <= state_next != state;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = state != S_IDLE;

endmodule

[sv/variable_partition_allocator_unit.sv]
// Partition allocator: one word in, one result word out. An allocate word
// scans the free-segment table one entry per cycle from a RAM with one
// write and one registered read port; when an exact fit removes a segment,
// the table is closed up afterwards. A release word scans the allocated
// table and then the free table, one entry per cycle, and then shifts the
// free table and the allocated table one entry per cycle.
// A new word is taken while the previous result still waits in the output
// register. After reset the INIT state builds the initial pool before the first
// word is taken; a pool_size write rebuilds the pool at once.
`include "variable_partition_allocator_unit_defines.svh"

module variable_partition_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  vpa_pkg::item_t              in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output vpa_pkg::result_t            out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vpa_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  vpa_pkg::cmd_t  cmd;
  vpa_pkg::stat_t stat;
  logic           cfg_we;
  logic [1:0]     fit_policy;
  logic [15:0]    pool_size;

  // Register port: always ready, indexed by the word address.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == vpa_pkg::REG_POOL_SIZE) ? {16'd0, pool_size}
                                                       : {30'd0, fit_policy};

  vpa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  vpa_datapath u_datapath (
    .clk(clk), .rst(rst),
    .cmd(cmd), .stat(stat),
    .in_data(in_data),
    .cfg_we(cfg_we), .cfg_idx(paddr[2]), .cfg_wdata(pwdata),
    .fit_policy(fit_policy), .pool_size(pool_size),
    .out_data(out_data)
  );

  // The block is busy from the word it takes until its result is loaded.
  `VPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted word did not make the block busy")
  // Merging with both neighbours closes the free table up next.
  `VPA_ASSERT_NEXT(a_merge_closes, cmd.op == vpa_pkg::OP_RMERGE && stat.merge_l && stat.merge_r, cmd.op == vpa_pkg::OP_FDOWN, "double merge did not close the free table")
  // A result appears only after the controller loaded it.
  `VPA_ASSERT_IMP(a_result_loaded, $rose(out_valid), $past(cmd.load_out), "result shown without a load")

endmodule

[dv/tb_variable_partition_allocator_unit.sv]
`timescale 1ns / 100ps

module tb_variable_partition_allocator_unit;

  // The spare policy code behaves as best fit.
  localparam logic [1:0] POLICY_SPARE = 2'd3;
  localparam int         DRAIN_CYCLES = 400;
  localparam longint     CYCLE_LIMIT  = 4000000;

  // Predicts allocator results and holds them until the block answers.
  class alloc_scoreboard;
    logic [1:0]       policy;
    int               pool;
    int               seg_start[vpa_pkg::FREE_SLOTS];
    int               seg_len[vpa_pkg::FREE_SLOTS];
    int               seg_count;
    int               blk_start[vpa_pkg::USED_SLOTS];
    int               blk_len[vpa_pkg::USED_SLOTS];
    int               blk_count;
    int               rover;
    vpa_pkg::result_t awaited[$];
    int               mismatches;

    function void rebuild_pool();
      blk_count = 0;
      rover     = 0;
      seg_count = (pool != 0) ? 1 : 0;
      seg_start[0] = 0;
      seg_len[0]   = pool;
    endfunction

    function void reset_state();
      policy     = vpa_pkg::POLICY_RESET;
      pool       = vpa_pkg::POOL_RESET;
      mismatches = 0;
      rebuild_pool();
    endfunction

    function void write_reg(logic reg_idx, logic [31:0] value);
      if (reg_idx == vpa_pkg::REG_FIT_POLICY) begin
        policy = value[1:0];
      end else begin
        pool = value[15:0];
        rebuild_pool();
      end
    endfunction

    function void drop_segment(int idx);
      for (int i = idx; i + 1 < seg_count; i++) begin
        seg_start[i] = seg_start[i + 1];
        seg_len[i]   = seg_len[i + 1];
      end
      seg_count--;
    endfunction

    function vpa_pkg::result_t allocate(int n);
      vpa_pkg::result_t r;
      int      miss;
      int      idx;
      int      pos;
      int      first;
      bit      hit;
      r = '0;
      miss = 0;
      idx = 0;
      hit = 0;
      if (n == 0) begin
        r.status = vpa_pkg::STATUS_NO_FIT;
        return r;
      end
      if (blk_count >= vpa_pkg::USED_SLOTS) begin
        r.status = vpa_pkg::STATUS_FULL;
        return r;
      end
      if (policy == vpa_pkg::POLICY_FIRST) begin
        for (int i = 0; i < seg_count && !hit; i++) begin
          if (seg_len[i] >= n) begin
            idx = i;
            hit = 1;
          end else begin
            miss++;
          end
        end
      end else if (policy == vpa_pkg::POLICY_NEXT) begin
        first = (rover < seg_count) ? rover : 0;
        for (int k = 0; k < seg_count && !hit; k++) begin
          pos = first + k;
          if (pos >= seg_count) pos -= seg_count;
          if (seg_len[pos] >= n) begin
            idx = pos;
            hit = 1;
          end else begin
            miss++;
          end
        end
      end else begin
        for (int i = 0; i < seg_count; i++) begin
          if (seg_len[i] < n) begin
            miss++;
          end else if (!hit || seg_len[i] < seg_len[idx]) begin
            idx = i;
            hit = 1;
          end
        end
      end
      r.probes = (miss > 127) ? vpa_pkg::PROBES_MAX : miss[6:0];
      if (!hit) begin
        r.status = vpa_pkg::STATUS_NO_FIT;
        return r;
      end
      r.block_addr = seg_start[idx][15:0];
      blk_start[blk_count] = seg_start[idx];
      blk_len[blk_count]   = n;
      blk_count++;
      if (seg_len[idx] > n) begin
        seg_start[idx] += n;
        seg_len[idx]   -= n;
      end else begin
        drop_segment(idx);
      end
      if (policy == vpa_pkg::POLICY_NEXT) rover = (idx < seg_count) ? idx : 0;
      r.status = vpa_pkg::STATUS_OK;
      return r;
    endfunction

    function vpa_pkg::result_t release_block(int a);
      vpa_pkg::result_t r;
      int      j;
      int      pos;
      int      len;
      bit      found;
      bit      join_l;
      bit      join_r;
      r = '0;
      r.block_addr = a[15:0];
      found = 0;
      for (j = 0; j < blk_count; j++) begin
        if (blk_start[j] == a) begin
          found = 1;
          break;
        end
      end
      if (!found) begin
        r.status = vpa_pkg::STATUS_NOT_ALLOC;
        return r;
      end
      len = blk_len[j];
      for (pos = 0; pos < seg_count; pos++) begin
        if (seg_start[pos] > a) break;
      end
      join_l = pos > 0 && seg_start[pos - 1] + seg_len[pos - 1] == a;
      join_r = pos < seg_count && a + len == seg_start[pos];
      if (join_l && join_r) begin
        seg_len[pos - 1] += len + seg_len[pos];
        drop_segment(pos);
      end else if (join_l) begin
        seg_len[pos - 1] += len;
      end else if (join_r) begin
        seg_start[pos] = a;
        seg_len[pos]  += len;
      end else begin
        if (seg_count >= vpa_pkg::FREE_SLOTS) begin
          r.status = vpa_pkg::STATUS_FULL;
          return r;
        end
        for (int i = seg_count; i > pos; i--) begin
          seg_start[i] = seg_start[i - 1];
          seg_len[i]   = seg_len[i - 1];
        end
        seg_start[pos] = a;
        seg_len[pos]   = len;
        seg_count++;
      end
      for (int i = j; i + 1 < blk_count; i++) begin
        blk_start[i] = blk_start[i + 1];
        blk_len[i]   = blk_len[i + 1];
      end
      blk_count--;
      r.status = vpa_pkg::STATUS_OK;
      return r;
    endfunction

    function void note_item(vpa_pkg::item_t it);
      vpa_pkg::result_t want;
      if (it.kind == vpa_pkg::KIND_ALLOC) want = allocate(it.req_size);
      else want = release_block(it.release_addr);
      awaited.insert(awaited.size(), want);
    endfunction

    function void check_result(vpa_pkg::result_t got);
      vpa_pkg::result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", got);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.block_addr !== want.block_addr ||
          got.probes !== want.probes) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result mismatch: expected status %0d addr %0d probes %0d, got %0d %0d %0d",
                   want.status, want.block_addr, want.probes,
                   got.status, got.block_addr, got.probes);
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  vpa_pkg::item_t               in_data;
  logic                         out_valid;
  logic                         out_stall;
  vpa_pkg::result_t             out_data;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [vpa_pkg::APB_AW-1:0]   paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  alloc_scoreboard     sb;
  int                  send_gap_pct;
  int                  stall_pct;
  logic                hold_off;
  longint              cycles = 0;

  variable_partition_allocator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random, or for a long stretch while held off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // Every result word taken by the receiver is checked in order.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_gap_pct = 63;
        stall_pct = 0;
      end
      2: begin
        send_gap_pct = 0;
        stall_pct = 63;
      end
      default: begin
        send_gap_pct = 13;
        stall_pct = 13;
      end
    endcase
  endtask

  // Offer one word, wait for it to be taken, then maybe leave a gap.
  task automatic send_word(vpa_pkg::item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_alloc(int n);
    vpa_pkg::item_t it;
    it = '0;
    it.kind = vpa_pkg::KIND_ALLOC;
    it.req_size = n[15:0];
    it.release_addr = $urandom_range(16'hFFFF);
    send_word(it);
  endtask

  task automatic send_release(int a);
    vpa_pkg::item_t it;
    it = '0;
    it.kind = vpa_pkg::KIND_RELEASE;
    it.release_addr = a[15:0];
    it.req_size = $urandom_range(16'hFFFF);
    send_word(it);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic write_reg(logic reg_idx, logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(reg_idx, value);
  endtask

  // Mostly small allocations and releases of live blocks, with some noise.
  task automatic random_word(int alloc_pct, int max_req);
    int pick;
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      case ($urandom_range(19))
        0:       send_alloc(0);
        1:       send_alloc($urandom_range(1, 16'hFFFF));
        2:       send_alloc(16'hFFFF);
        default: send_alloc($urandom_range(1, max_req));
      endcase
    end else if (sb.blk_count != 0 && $urandom_range(9) != 0) begin
      send_release(sb.blk_start[$urandom_range(sb.blk_count - 1)]);
    end else begin
      send_release($urandom_range(16'hFFFF));
    end
  endtask

  task automatic hold_receiver(int span);
    hold_off <= 1'b1;
    repeat (span) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  initial begin
    logic [1:0] policies[8];
    int         pools[8];
    int         max_reqs[8];
    int         alloc_bias;
    sb = new();
    sb.reset_state();
    hold_off = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    set_idling(0);
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset pool, extremes of the request and release fields.
    send_alloc(0);
    send_alloc(16'hFFFF);
    send_alloc(1);
    send_alloc(9999);
    send_alloc(1);
    send_release(0);
    send_release(0);
    send_release(16'hFFFF);
    send_release(1);
    send_alloc(10000);
    send_release(0);
    write_reg(vpa_pkg::REG_POOL_SIZE, 32'd0);
    send_alloc(1);
    send_release(0);
    write_reg(vpa_pkg::REG_POOL_SIZE, 32'd65535);
    send_alloc(16'hFFFF);
    send_release(0);
    write_reg(vpa_pkg::REG_POOL_SIZE, 32'd1);
    send_alloc(1);
    send_alloc(1);
    send_release(0);

    // Random phases across the fit policies and pool sizes.
    policies = '{vpa_pkg::POLICY_FIRST, vpa_pkg::POLICY_NEXT, vpa_pkg::POLICY_BEST,
                 POLICY_SPARE, vpa_pkg::POLICY_NEXT, vpa_pkg::POLICY_FIRST,
                 vpa_pkg::POLICY_BEST, vpa_pkg::POLICY_NEXT};
    pools    = '{200, 300, 65535, 1, 1000, 150, 40, 0};
    max_reqs = '{8, 12, 3000, 2, 40, 4, 6, 4};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(vpa_pkg::REG_FIT_POLICY, {30'd0, policies[ph]});
      write_reg(vpa_pkg::REG_POOL_SIZE, pools[ph]);
      alloc_bias = (ph % 2 == 0) ? 70 : 55;
      if (ph == 0) begin
        set_idling(0);
        fork
          hold_receiver(3000);
        join_none
      end
      for (int n = 0; n < 135; n++) begin
        if (n % 34 == 0 && !(ph == 0 && n == 0)) set_idling(ph + n / 34);
        random_word(alloc_bias, max_reqs[ph]);
      end
    end
    in_valid <= 1'b0;
    set_idling(0);

    // Drain, then allow the block its worst-case latency to settle.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[variable_partition_allocator_unit.f]
+incdir+sv
sv/vpa_pkg.sv
sv/vpa_ram.sv
sv/vpa_datapath.sv
sv/vpa_ctrl.sv
sv/variable_partition_allocator_unit.sv
dv/tb_variable_partition_allocator_unit.sv
